// ===== rtl/tensor_element_to_fp32_converter_core_assert.svh =====
// assertion macros for the checker file of the converter core
// expects clk and arst_n in the scope where a macro is used
`ifndef TENSOR_ELEMENT_TO_FP32_CONVERTER_CORE_ASSERT_SVH
`define TENSOR_ELEMENT_TO_FP32_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication
`define TEFC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define TEFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/tefc_pkg.sv =====
// types, constants and the half to single conversion function of the converter core
// no dependencies
package tefc_pkg;

	typedef enum logic [1:0] {
		FMT_F32  = 2'd0,
		FMT_BF16 = 2'd1,
		FMT_F16  = 2'd2,
		FMT_RSVD = 2'd3
	} fmt_t;

	// one assembled element on its way from the front to the back
	typedef struct packed {
		logic [31:0] raw;
		fmt_t        fmt;
		logic        last;
	} elem_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [7:0] SGL_EXP_BIAS  = 8'd127;
	localparam logic [7:0] HALF_EXP_BIAS = 8'd15;
	localparam logic [7:0] EXP_REBIAS    = SGL_EXP_BIAS - HALF_EXP_BIAS;
	localparam logic [4:0] HALF_EXP_MAX  = 5'h1f;
	localparam logic [7:0] SGL_EXP_MAX   = 8'hff;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic       sgn;
		logic [4:0] ex;
		logic [9:0] man;
		logic [3:0] lzc;
		logic       found;
		logic [9:0] shifted;
		logic [7:0] exp_sub;
		logic [31:0] res;
		sgn = h[15];
		ex = h[14:10];
		man = h[9:0];
		lzc = '0;
		found = 1'b0;
		for (int i = 9; i >= 0; i--) begin
			if (!found) begin
				if (man[i]) begin
					found = 1'b1;
				end else begin
					lzc = lzc + 4'd1;
				end
			end
		end
		shifted = man << lzc;
		exp_sub = EXP_REBIAS - {4'b0, lzc};
		if (ex == 5'd0) begin
			if (man == 10'd0) begin
				res = {sgn, 31'b0};
			end else begin
				// leading one drops out, bits below it form the mantissa
				res = {sgn, exp_sub, shifted[8:0], 14'b0};
			end
		end else if (ex == HALF_EXP_MAX) begin
			res = {sgn, SGL_EXP_MAX, man, 13'b0};
		end else begin
			res = {sgn, {3'b0, ex} + EXP_REBIAS, man, 13'b0};
		end
		return res;
	endfunction

endpackage

// ===== rtl/tefc_queue.sv =====
// small register queue between the byte assembler and the converter
// depends on tefc_pkg for the status type
module tefc_queue #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output tefc_pkg::q_stat_t stat
);
	import tefc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/tefc_front.sv =====
// front end: takes bytes, holds the element format and assembles elements
// depends on tefc_pkg
module tefc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  tefc_pkg::q_stat_t q_stat,
	output logic              push,
	output tefc_pkg::elem_t   push_elem
);
	import tefc_pkg::*;

	fmt_t        fmt_q;
	logic [1:0]  pos_q;
	logic [23:0] partial_q;
	logic        take;
	logic        complete;

	assign in_ready = !q_stat.full;
	assign take     = in_valid && in_ready;

	always_comb begin
		case (fmt_q)
			FMT_F32:  complete = (pos_q == 2'd3);
			FMT_BF16: complete = (pos_q == 2'd1);
			FMT_F16:  complete = (pos_q == 2'd1);
			default:  complete = 1'b0;
		endcase
	end

	assign push           = take && complete;
	assign push_elem.fmt  = fmt_q;
	assign push_elem.last = in_last;
	assign push_elem.raw  = (fmt_q == FMT_F32) ? {in_byte, partial_q}
	                                           : {16'b0, in_byte, partial_q[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= FMT_F32;
			pos_q     <= '0;
			partial_q <= '0;
		end else if (cfg_wr_en) begin
			fmt_q     <= fmt_t'(cfg_wr_data);
			pos_q     <= '0;
			partial_q <= '0;
		end else if (take) begin
			// a finished element, a tensor end or the reserved format restarts assembly
			if (complete || in_last || fmt_q == FMT_RSVD) begin
				pos_q     <= '0;
				partial_q <= '0;
			end else begin
				pos_q <= pos_q + 2'd1;
				case (pos_q)
					2'd0:    partial_q[7:0]   <= in_byte;
					2'd1:    partial_q[15:8]  <= in_byte;
					2'd2:    partial_q[23:16] <= in_byte;
					default: partial_q        <= partial_q;
				endcase
			end
		end
	end

endmodule

// ===== rtl/tefc_back.sv =====
// back end: converts queued elements and holds the output word register
// depends on tefc_pkg
module tefc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tefc_pkg::q_stat_t q_stat,
	input  tefc_pkg::elem_t   pop_elem,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_bits,
	output logic              out_last
);
	import tefc_pkg::*;

	logic        valid_q;
	logic [31:0] bits_q;
	logic        last_q;
	logic [31:0] conv;

	assign pop = !q_stat.empty && (!valid_q || out_ready);

	always_comb begin
		case (pop_elem.fmt)
			FMT_F32:  conv = pop_elem.raw;
			FMT_BF16: conv = {pop_elem.raw[15:0], 16'b0};
			FMT_F16:  conv = half_to_single(pop_elem.raw[15:0]);
			default:  conv = pop_elem.raw;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bits_q <= conv;
			last_q <= pop_elem.last;
		end
	end

	assign out_valid = valid_q;
	assign out_bits  = bits_q;
	assign out_last  = last_q;

endmodule

// ===== rtl/tensor_element_to_fp32_converter_core.sv =====
// a result word passes through the element queue and the output register before it shows on m_axis
// throughput: one byte per cycle while the element queue is not full, bounded by the byte handshake of the assembler
// the queue lets bytes flow while a result word waits in the output register
// arst_n clears the format to f32, the assembly state, the queue and the output valid
// top level: byte assembler, element queue and converter with output register
// depends on tefc_pkg, tefc_front, tefc_queue, tefc_back
module tensor_element_to_fp32_converter_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,    // element_format
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // single_bits
	output logic        m_axis_tlast    // last_element
);
	import tefc_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	elem_t   push_elem;
	elem_t   pop_elem;

	tefc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_stat    (q_stat),
		.push      (push),
		.push_elem (push_elem)
	);

	tefc_queue #(
		.WIDTH ($bits(elem_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_elem),
		.pop       (pop),
		.pop_data  (pop_elem),
		.stat      (q_stat)
	);

	tefc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_elem  (pop_elem),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_bits  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== rtl/tefc_checker.sv =====
// port-level checks for the converter core, attached by bind
// depends on tensor_element_to_fp32_converter_core_assert.svh
`include "tensor_element_to_fp32_converter_core_assert.svh"

module tefc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled word stays offered
	`TEFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// a stalled word keeps its payload
	`TEFC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`TEFC_ASSERT_NEXT(a_last_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tlast))

	// a fresh word only appears after a byte was taken and passed through the element queue and the output register
	`TEFC_ASSERT_SAME(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind tensor_element_to_fp32_converter_core tefc_checker u_tefc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tensor_element_to_fp32_converter_core_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for the tensor element to fp32 converter core: random bytes in all formats
// depends on tefc_pkg and tensor_element_to_fp32_converter_core
module tensor_element_to_fp32_converter_core_test;
	import tefc_pkg::fmt_t;
	import tefc_pkg::FMT_F32;
	import tefc_pkg::FMT_BF16;
	import tefc_pkg::FMT_F16;
	import tefc_pkg::FMT_RSVD;

	localparam int        RANDOM_BYTES     = 800;
	localparam int        SETTLE_CYCLES    = 8;
	localparam int        LONG_HOLD_CYCLES = 300;
	localparam int        CYCLE_LIMIT      = 400000;
	localparam logic [7:0] HALF_REBIAS     = 8'd112;
	localparam logic [4:0] HALF_EXP_ALL1   = 5'h1f;
	localparam logic [7:0] SINGLE_EXP_ALL1 = 8'hff;

	typedef struct {
		logic [31:0] bits;
		logic        last;
	} fp32_word_t;

	class word_scoreboard;
		fmt_t       fmt = FMT_F32;
		int         byte_pos = 0;
		logic [23:0] partial = '0;
		fp32_word_t expected_words[$];
		int         errors = 0;

		function void set_format(fmt_t f);
			fmt = f;
			byte_pos = 0;
			partial = '0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function logic [31:0] widen_half(logic [15:0] h);
			logic [4:0] ex;
			logic [9:0] man;
			int         lead_zeros;
			ex = h[14:10];
			man = h[9:0];
			if (ex == 5'd0) begin
				if (man == 10'd0)
					return {h[15], 31'b0};
				lead_zeros = 0;
				while (!man[9]) begin
					man = man << 1;
					lead_zeros++;
				end
				// hidden one falls off the top
				man = man << 1;
				return {h[15], HALF_REBIAS - 8'(lead_zeros), man, 13'b0};
			end
			if (ex == HALF_EXP_ALL1)
				return {h[15], SINGLE_EXP_ALL1, man, 13'b0};
			return {h[15], {3'b0, ex} + HALF_REBIAS, man, 13'b0};
		endfunction

		// called for every byte the core takes
		function void note_byte(logic [7:0] data, logic last);
			int          elem_size;
			logic [31:0] assembled;
			fp32_word_t  w;
			case (fmt)
				FMT_F32: elem_size = 4;
				FMT_BF16, FMT_F16: elem_size = 2;
				default: begin
					set_format(fmt);
					return;
				end
			endcase
			assembled = {8'b0, partial} | ({24'b0, data} << (8 * byte_pos));
			if (byte_pos + 1 < elem_size) begin
				if (last) begin
					byte_pos = 0;
					partial = '0;
				end else begin
					partial = assembled[23:0];
					byte_pos++;
				end
				return;
			end
			case (fmt)
				FMT_F32:  w.bits = assembled;
				FMT_BF16: w.bits = {assembled[15:0], 16'b0};
				default:  w.bits = widen_half(assembled[15:0]);
			endcase
			w.last = last;
			byte_pos = 0;
			partial = '0;
			expected_words.push_back(w);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_word(logic [31:0] bits, logic last);
			fp32_word_t w;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h last %b", bits, last));
				return;
			end
			w = expected_words.pop_front();
			if (bits !== w.bits)
				report_mismatch($sformatf("bits %h, expected %h", bits, w.bits));
			if (last !== w.last)
				report_mismatch($sformatf("last %b, expected %b (bits %h)", last, w.last, w.bits));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_wr_data = 2'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;    // data_byte
	logic        s_axis_tlast = 1'b0;    // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // single_bits
	logic        m_axis_tlast;           // last_element

	word_scoreboard sb = new;
	int cycle_count = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;

	tensor_element_to_fp32_converter_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tlast);
	end

	// receiver: the stall pattern is picked anew after each random span, plus one long hold-off
	initial begin
		int mode;
		int span;
		mode = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(16, 96);
				end
				span--;
				case (mode)
					0, 1: m_axis_tready <= 1'b1;
					2: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// offer one byte and wait until it is taken; gaps fall between bursts
	task send_byte(logic [7:0] data, logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(data, last);
	endtask

	// only written once the core has nothing in flight
	task write_format(fmt_t f);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_format(f);
	endtask

	// leans toward zero/subnormal and inf/nan exponents so f16 corners come up often
	function logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return {1'($urandom_range(0, 1)), 5'b0, 2'($urandom_range(0, 3))};
			1: return {1'($urandom_range(0, 1)), 5'h1f, 2'($urandom_range(0, 3))};
			2: return 8'h00;
			3: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [15:0] halves [8];
		int   counted;
		int   phase;
		int   n;
		fmt_t f;
		logic last;
		halves = '{16'h0000, 16'h8000, 16'h0001, 16'h03ff,
			16'h7c00, 16'h7e01, 16'h3c00, 16'hfbff};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// f32 straight out of reset, then a partial element dropped by a format change
		send_byte(8'h78, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h12, 1'b1);
		send_byte(8'hff, 1'b0);
		s_axis_tvalid <= 1'b0;
		write_format(FMT_F16);
		foreach (halves[i]) begin
			send_byte(halves[i][7:0], 1'b0);
			send_byte(halves[i][15:8], i == 7);
		end
		// trailing partial element is dropped
		send_byte(8'h3c, 1'b1);
		s_axis_tvalid <= 1'b0;
		write_format(FMT_BF16);
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b1);
		s_axis_tvalid <= 1'b0;
		write_format(FMT_RSVD);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b1);
		s_axis_tvalid <= 1'b0;

		counted = 0;
		phase = 0;
		while (counted < RANDOM_BYTES) begin
			if (phase == 0) begin
				f = FMT_BF16;
				n = 64;
			end else begin
				case ($urandom_range(0, 9))
					0: f = FMT_RSVD;
					1, 2, 3: f = FMT_F32;
					4, 5, 6: f = FMT_BF16;
					default: f = FMT_F16;
				endcase
				n = $urandom_range(8, 64);
			end
			write_format(f);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (phase == 0)
				hold_req = 1'b1;
			for (int i = 0; i < n; i++) begin
				last = ($urandom_range(0, 15) == 0);
				send_byte(pick_byte(), last);
				if (f != FMT_RSVD)
					counted++;
			end
			s_axis_tvalid <= 1'b0;
			phase++;
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
